// ===== hw/rtl/msort_pkg.sv =====
// msort_pkg: shared types and constants for the merge_sorter block.
// Used by msort_cell and merge_sorter; depends on nothing else.
`timescale 1ns / 1ps

package msort_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // one cell's contents as seen by its neighbors
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
    } slot_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/msort_cell.sv =====
// msort_cell: one slot of the sorting chain, holds one element and a valid bit.
// Insert places a new element in order; shift hands contents toward cell 0.
// Depends on msort_pkg.
`timescale 1ns / 1ps

module msort_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  msort_pkg::cell_ctrl_t             ctrl,
    input  logic signed [msort_pkg::DATA_W-1:0] new_value,
    input  msort_pkg::slot_t                  prev_slot,
    input  logic                              prev_ins,
    input  msort_pkg::slot_t                  next_slot,
    output msort_pkg::slot_t                  slot,
    output logic                              ins
);

    logic                               valid_reg;
    logic                               valid_next;
    logic signed [msort_pkg::DATA_W-1:0] value_reg;
    logic signed [msort_pkg::DATA_W-1:0] value_next;

    // new element belongs at or before this slot
    assign ins = !valid_reg || (new_value < value_reg);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        priority if (ctrl.shift)
        begin
            valid_next = next_slot.valid;
            value_next = next_slot.value;
        end
        else if (ctrl.insert && ins)
        begin
            valid_next = prev_ins ? prev_slot.valid : 1'b1;
            value_next = prev_ins ? prev_slot.value : new_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign slot.valid = valid_reg;
    assign slot.value = value_reg;

endmodule

// ===== hw/rtl/merge_sorter.sv =====
// merge_sorter: top level, a chain of msort_cell slots kept in ascending order.
// Depends on msort_pkg and msort_cell.
//
// channel  direction  handshake               payload
// load     in         start & !busy           value, last
// result   out        result_strobe           sorted_value, final_res
//
// Loading takes one element per cycle while busy is low; each element drops into its ordered slot.
// After the transaction with last set, the n held elements leave one per cycle,
// smallest first; busy is high while they drain.
// The shift of the cell chain toward cell 0 sets the output rate.
// Reset clears all valid bits and returns to loading; the receiver cannot stall.
// Elements arriving while all DEPTH cells are full are dropped.
`timescale 1ns / 1ps

module merge_sorter #(
    parameter int DEPTH = msort_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [msort_pkg::DATA_W-1:0] value,
    input  logic                                last,
    output logic                                result_strobe,
    output logic signed [msort_pkg::DATA_W-1:0] sorted_value,
    output logic                                final_res
);

    msort_pkg::state_t     state_reg;
    msort_pkg::state_t     state_next;
    msort_pkg::cell_ctrl_t ctrl;
    msort_pkg::slot_t      slots [DEPTH];
    logic [DEPTH-1:0]      ins_vec;
    logic                  accept;
    logic                  full;

    assign accept = start && !busy;
    assign full   = slots[DEPTH-1].valid;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            msort_pkg::slot_t prev_s;
            msort_pkg::slot_t next_s;
            logic             prev_i;

            if (g == 0)
            begin : g_head
                assign prev_s = '0;
                assign prev_i = 1'b0;
            end
            else
            begin : g_body
                assign prev_s = slots[g-1];
                assign prev_i = ins_vec[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign next_s = '0;
            end
            else
            begin : g_mid
                assign next_s = slots[g+1];
            end

            msort_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .new_value (value),
                .prev_slot (prev_s),
                .prev_ins  (prev_i),
                .next_slot (next_s),
                .slot      (slots[g]),
                .ins       (ins_vec[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msort_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctrl.insert = 1'b0;
        ctrl.shift  = 1'b0;
        busy        = 1'b0;
        unique case (state_reg)
            msort_pkg::ST_LOAD:
            begin
                ctrl.insert = accept && !full;
                if (accept && last)
                begin
                    state_next = msort_pkg::ST_DRAIN;
                end
            end
            msort_pkg::ST_DRAIN:
            begin
                busy       = 1'b1;
                ctrl.shift = 1'b1;
                if (!slots[1].valid)
                begin
                    state_next = msort_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = msort_pkg::ST_LOAD;
            end
        endcase
    end

    assign result_strobe = (state_reg == msort_pkg::ST_DRAIN);
    assign sorted_value  = slots[0].value;
    assign final_res     = result_strobe && !slots[1].valid;

    a_strobe_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> slots[0].valid)
        else $error("result strobe without a held element");

    a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> result_strobe)
        else $error("no output after last element");

    a_final_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && final_res |=> !busy && !slots[0].valid)
        else $error("chain not empty after final result");

    a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !final_res |=> result_strobe)
        else $error("drain stopped early");

    a_chain_order: assert property (@(posedge clk) disable iff (!rst_n)
        slots[1].valid |-> slots[0].valid && (slots[0].value <= slots[1].value))
        else $error("head of chain out of order");

endmodule

// ===== bench/tb_merge_sorter.sv =====
// tb_merge_sorter: self-checking testbench for the merge_sorter block.
// Loads lists, predicts the ascending output and checks each result in order.
// Depends on msort_pkg and merge_sorter.
`timescale 1ns / 1ps

module tb_merge_sorter;

    localparam int DEPTH         = msort_pkg::DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_ITEMS  = 75;

    typedef logic signed [msort_pkg::DATA_W-1:0] elem_t;

    typedef struct {
        elem_t value;
        logic  fin;
    } sorted_item_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  start;
    logic  busy;
    elem_t value;
    logic  last;
    logic  result_strobe;
    elem_t sorted_value;
    logic  final_res;

    elem_t        held_elements[$];
    sorted_item_t pending_sorted[$];
    sorted_item_t head_item;

    int mismatches      = 0;
    int lists_sorted    = 0;
    int elements_loaded = 0;
    int results_checked = 0;
    int idle_cycles     = 0;
    int burst_left      = 0;

    merge_sorter #(
        .DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .result_strobe(result_strobe),
        .sorted_value (sorted_value),
        .final_res    (final_res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic absorb_element(input elem_t v, input logic is_last);
        elem_t        run[$];
        elem_t        tmp;
        sorted_item_t item;
        int           i;
        int           j;
        if (held_elements.size() < DEPTH)
            held_elements.push_back(v);
        if (is_last)
        begin
            run = held_elements;
            for (i = 1; i < run.size(); i++)
            begin
                tmp = run[i];
                j = i - 1;
                while (j >= 0 && run[j] > tmp)
                begin
                    run[j + 1] = run[j];
                    j--;
                end
                run[j + 1] = tmp;
            end
            for (i = 0; i < run.size(); i++)
            begin
                item.value = run[i];
                item.fin   = (i == run.size() - 1);
                pending_sorted.push_back(item);
            end
            held_elements.delete();
            lists_sorted++;
        end
    endtask

    function automatic elem_t pick_value();
        case ($urandom_range(0, 9))
            0:       return elem_t'(32'h8000_0000);
            1:       return elem_t'(32'h7fff_ffff);
            2, 3:    return elem_t'($urandom_range(0, 8)) - elem_t'(4);
            default: return elem_t'($urandom);
        endcase
    endfunction

    task automatic send_element(input elem_t v, input logic is_last);
        @(negedge clk);
        start <= 1'b1;
        value <= v;
        last  <= is_last;
        do
            @(posedge clk);
        while (busy);
        absorb_element(v, is_last);
        elements_loaded++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            @(negedge clk);
            start <= 1'b0;
            value <= elem_t'($urandom);
            last  <= 1'($urandom);
            repeat ($urandom_range(0, 6))
                @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    task automatic wait_sorted_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic test_single_element();
        send_element(elem_t'(32'h1234_5678), 1'b1);
        wait_sorted_drained();
    endtask

    task automatic test_extreme_values();
        send_element(elem_t'(32'h7fff_ffff), 1'b0);
        send_element(elem_t'(32'h8000_0000), 1'b0);
        send_element(elem_t'(0), 1'b0);
        send_element(elem_t'(-1), 1'b0);
        send_element(elem_t'(1), 1'b0);
        send_element(elem_t'(32'h8000_0000), 1'b1);
        wait_sorted_drained();
    endtask

    task automatic test_full_store();
        int i;
        for (i = 0; i < DEPTH; i++)
            send_element(elem_t'($urandom_range(0, 1000)) - elem_t'(500), 1'b0);
        send_element(elem_t'(32'h8000_0000), 1'b0);
        send_element(elem_t'(32'h7fff_ffff), 1'b1);
        wait_sorted_drained();
    endtask

    task automatic test_random_lists();
        int start_count;
        int list_len;
        int i;
        start_count = elements_loaded;
        while (elements_loaded - start_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                list_len = $urandom_range(DEPTH, DEPTH + 4);
            else
                list_len = $urandom_range(1, DEPTH);
            for (i = 0; i < list_len; i++)
                send_element(pick_value(), i == list_len - 1);
            if ($urandom_range(0, 3) == 0)
                wait_sorted_drained();
        end
        wait_sorted_drained();
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_strobe === 1'b1)
        begin
            if (pending_sorted.size() == 0)
                report_mismatch($sformatf("unexpected result %0d", sorted_value));
            else
            begin
                head_item = pending_sorted.pop_front();
                results_checked++;
                if (sorted_value !== head_item.value)
                    report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                              sorted_value, head_item.value));
                if (final_res !== head_item.fin)
                    report_mismatch($sformatf("final_res %b, expected %b",
                                              final_res, head_item.fin));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || result_strobe === 1'b1)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transaction", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        last  = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_element();
        test_extreme_values();
        test_full_store();
        test_random_lists();

        if (pending_sorted.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_sorted.size()));
        $display("Sorted %0d lists from %0d loaded elements, %0d results checked",
                 lists_sorted, elements_loaded, results_checked);
        $display("Covered single, extreme, duplicate and overflowing lists");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== merge_sorter.f =====
hw/rtl/msort_pkg.sv
hw/rtl/msort_cell.sv
hw/rtl/merge_sorter.sv
bench/tb_merge_sorter.sv
